FILE: rtl/core/btms_pkg.sv
// ----------------------------------------------------------------------------
// btms_pkg
// Shared types, codes and the PWM duty table of the board test mode sequencer.
// ----------------------------------------------------------------------------
package btms_pkg;

   // Operating modes
   typedef enum logic [2:0] {
      MODE_SCAN   = 3'd0,
      MODE_BATLOW = 3'd1,
      MODE_PWM    = 3'd2,
      MODE_MOTOR1 = 3'd3,
      MODE_MOTOR2 = 3'd4
   } mode_type;

   // Display event codes
   localparam logic [2:0] EV_NONE    = 3'd0;
   localparam logic [2:0] EV_SENSOR  = 3'd1;
   localparam logic [2:0] EV_BATLOW  = 3'd2;
   localparam logic [2:0] EV_CLEARED = 3'd3;
   localparam logic [2:0] EV_DUTY    = 3'd4;
   localparam logic [2:0] EV_MOTOR1  = 3'd5;
   localparam logic [2:0] EV_MOTOR2  = 3'd6;

   localparam int unsigned DUTY_STEPS = 6;
   localparam int unsigned REQ_BYTES  = 1;
   localparam int unsigned RSP_BYTES  = 3;
   localparam logic [15:0] PERIOD_RESET = 16'd30;

   // One tick request (button and battery levels)
   typedef struct packed {
      logic battery_low;
      logic button2;
      logic button1;
      logic button0;
   } req_type;

   // One result, lowest field in the lowest bits
   typedef struct packed {
      logic [2:0] display_event;
      logic       motor2_in2;
      logic       motor2_in1;
      logic       motor1_in2;
      logic       motor1_in1;
      logic       standby2;
      logic       standby1;
      logic [7:0] duty_level;
      logic [2:0] sensor_select;
      logic [2:0] mode;
   } rsp_type;

   // PWM duty table; steps 6 and 7 are never used
   function automatic logic [7:0] duty_lookup(input logic [2:0] step);
      logic [7:0] duty;
      case (step)
         3'd0:    duty = 8'h32;
         3'd1:    duty = 8'h56;
         3'd2:    duty = 8'h7F;
         3'd3:    duty = 8'h99;
         3'd4:    duty = 8'hA8;
         3'd5:    duty = 8'hFF;
         default: duty = 8'h00;
      endcase
      return duty;
   endfunction

endpackage

FILE: rtl/core/btms_in_reg.sv
// ----------------------------------------------------------------------------
// btms_in_reg
// Request register: captures one tick request and holds it until the
// update stage takes it.
// ----------------------------------------------------------------------------
module btms_in_reg (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  btms_pkg::req_type in_req,
   output logic              out_valid,
   input  logic              out_ready,
   output btms_pkg::req_type out_req
);

   logic              valid_ff;
   logic              valid_in;
   btms_pkg::req_type req_ff;
   logic              take;

   // Accept when empty or when the held request moves on this cycle
   assign in_ready = !valid_ff || out_ready;
   assign take     = in_valid && in_ready;
   assign valid_in = take ? 1'b1 : (out_ready ? 1'b0 : valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (take) begin
         req_ff <= in_req;
      end
   end

   assign out_valid = valid_ff;
   assign out_req   = req_ff;

endmodule

FILE: rtl/core/btms_step.sv
// ----------------------------------------------------------------------------
// btms_step
// Mode state and one-tick update: sensor scan, battery low, PWM and motor
// tests. Builds the result of a tick from the updated state.
// ----------------------------------------------------------------------------
module btms_step (
   input  logic              clock,
   input  logic              reset,
   input  logic              advance,
   input  logic [15:0]       period,
   input  btms_pkg::req_type req,
   output btms_pkg::rsp_type rsp
);

   btms_pkg::mode_type mode_ff, mode_in;
   logic [15:0]        tick_ff, tick_in;
   logic [2:0]         sensor_ff, sensor_in;
   logic [2:0]         step_ff, step_in;
   logic [7:0]         duty_ff, duty_in;
   logic [2:0]         last_ff, last_in;
   logic [1:0]         standby_ff, standby_in;
   logic [3:0]         motor_ff, motor_in;
   logic [2:0]         event_code;
   logic [15:0]        tick_inc;
   logic               done;
   logic [2:0]         sensor_next;

   // Period counter shared by scan and test modes
   assign tick_inc    = tick_ff + 16'd1;
   assign done        = (tick_inc == period);
   assign sensor_next = (sensor_ff >= 3'd4) ? 3'd1 : sensor_ff + 3'd1;

   // Tick update
   always_comb begin
      mode_in    = mode_ff;
      tick_in    = tick_ff;
      sensor_in  = sensor_ff;
      step_in    = step_ff;
      duty_in    = duty_ff;
      last_in    = last_ff;
      standby_in = standby_ff;
      motor_in   = motor_ff;
      event_code = btms_pkg::EV_NONE;
      case (mode_ff)
         btms_pkg::MODE_SCAN: begin
            tick_in = done ? 16'd0 : tick_inc;
            if (done) begin
               sensor_in = sensor_next;
            end
            event_code = btms_pkg::EV_SENSOR;
            if (req.battery_low) begin
               mode_in    = btms_pkg::MODE_BATLOW;
               tick_in    = 16'd0;
               event_code = btms_pkg::EV_BATLOW;
            end else begin
               // buttons checked in order, last rising edge wins
               if (req.button0 && !last_ff[0]) begin
                  mode_in    = btms_pkg::MODE_PWM;
                  tick_in    = 16'd0;
                  standby_in = 2'b11;
                  motor_in   = 4'b0101;
                  duty_in    = btms_pkg::duty_lookup(3'd0);
                  step_in    = 3'd1;
                  event_code = btms_pkg::EV_DUTY;
               end
               if (req.button1 && !last_ff[1]) begin
                  mode_in    = btms_pkg::MODE_MOTOR1;
                  tick_in    = 16'd0;
                  standby_in = 2'b01;
                  motor_in   = {motor_in[3:2], 2'b01};
                  event_code = btms_pkg::EV_MOTOR1;
               end
               if (req.button2 && !last_ff[2]) begin
                  mode_in    = btms_pkg::MODE_MOTOR2;
                  tick_in    = 16'd0;
                  standby_in = 2'b10;
                  motor_in   = {2'b01, motor_in[1:0]};
                  event_code = btms_pkg::EV_MOTOR2;
               end
               last_in = {req.button2, req.button1, req.button0};
            end
         end
         btms_pkg::MODE_BATLOW: begin
            if (!req.battery_low) begin
               mode_in    = btms_pkg::MODE_SCAN;
               event_code = btms_pkg::EV_CLEARED;
            end
         end
         btms_pkg::MODE_PWM: begin
            tick_in = done ? 16'd0 : tick_inc;
            if (done && (step_ff < 3'(btms_pkg::DUTY_STEPS))) begin
               duty_in    = btms_pkg::duty_lookup(step_ff);
               step_in    = (step_ff == 3'(btms_pkg::DUTY_STEPS - 1)) ? 3'd0 : step_ff + 3'd1;
               event_code = btms_pkg::EV_DUTY;
            end
            if (!req.button0 && last_ff[0]) begin
               mode_in    = btms_pkg::MODE_SCAN;
               standby_in = 2'b00;
               tick_in    = 16'd0;
            end
            last_in[0] = req.button0;
         end
         btms_pkg::MODE_MOTOR1: begin
            tick_in = done ? 16'd0 : tick_inc;
            if (done) begin
               motor_in   = motor_ff ^ 4'b0011;
               event_code = btms_pkg::EV_MOTOR1;
            end
            if (!req.button1 && last_ff[1]) begin
               mode_in    = btms_pkg::MODE_SCAN;
               standby_in = 2'b00;
               tick_in    = 16'd0;
            end
            last_in[1] = req.button1;
         end
         btms_pkg::MODE_MOTOR2: begin
            tick_in = done ? 16'd0 : tick_inc;
            if (done) begin
               motor_in   = motor_ff ^ 4'b1100;
               event_code = btms_pkg::EV_MOTOR2;
            end
            if (!req.button2 && last_ff[2]) begin
               mode_in    = btms_pkg::MODE_SCAN;
               standby_in = 2'b00;
               tick_in    = 16'd0;
            end
            last_in[2] = req.button2;
         end
         default: begin
            event_code = btms_pkg::EV_NONE;
         end
      endcase
   end

   // State registers, updated once per tick
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= btms_pkg::MODE_SCAN;
         tick_ff    <= 16'd0;
         sensor_ff  <= 3'd1;
         step_ff    <= 3'd0;
         duty_ff    <= 8'd0;
         last_ff    <= 3'd0;
         standby_ff <= 2'd0;
         motor_ff   <= 4'd0;
      end else if (advance) begin
         mode_ff    <= mode_in;
         tick_ff    <= tick_in;
         sensor_ff  <= sensor_in;
         step_ff    <= step_in;
         duty_ff    <= duty_in;
         last_ff    <= last_in;
         standby_ff <= standby_in;
         motor_ff   <= motor_in;
      end
   end

   // Result of this tick, taken after the update
   always_comb begin
      rsp.mode          = mode_in;
      rsp.sensor_select = sensor_in;
      rsp.duty_level    = duty_in;
      rsp.standby1      = standby_in[0];
      rsp.standby2      = standby_in[1];
      rsp.motor1_in1    = motor_in[0];
      rsp.motor1_in2    = motor_in[1];
      rsp.motor2_in1    = motor_in[2];
      rsp.motor2_in2    = motor_in[3];
      rsp.display_event = event_code;
   end

endmodule

FILE: rtl/core/board_test_mode_sequencer.sv
// ----------------------------------------------------------------------------
// board_test_mode_sequencer
// Top level: request register, tick update, result register and the
// period register.
// ----------------------------------------------------------------------------
// Each request is one loop tick with three button levels and a battery-low
// level; each produces exactly one result with the mode, sensor select, duty,
// driver pins and a display event code. A request passes through the request
// register and then the result register, and one request can enter every cycle
// as long as results are taken; the combinational tick update between the two
// registers allows that rate. The period register (ticks per period, reset 30,
// 0 acting as 65536) is written through the csr channel and should only be
// changed while no request is in flight.
module board_test_mode_sequencer (
   input  logic        clock,
   input  logic        reset,
   // request: [0] button0, [1] button1, [2] button2, [3] battery_low, [7:4] zero
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,
   // result: [2:0] mode, [5:3] sensor_select, [13:6] duty_level, [14] standby1,
   // [15] standby2, [16] motor1_in1, [17] motor1_in2, [18] motor2_in1,
   // [19] motor2_in2, [22:20] display_event, [23] zero
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,
   // ticks per period
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [15:0] csr_data
);

   logic              stage_valid;
   logic              stage_ready;
   btms_pkg::req_type req_in;
   btms_pkg::req_type stage_req;
   btms_pkg::rsp_type step_rsp;
   btms_pkg::rsp_type rsp_ff;
   logic              rsp_valid_ff;
   logic              rsp_valid_in;
   logic              advance;
   logic [15:0]       period_ff;

   // Unpack request
   always_comb begin
      req_in.button0     = req_tdata[0];
      req_in.button1     = req_tdata[1];
      req_in.button2     = req_tdata[2];
      req_in.battery_low = req_tdata[3];
   end

   btms_in_reg u_in_reg (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_req    (req_in),
      .out_valid (stage_valid),
      .out_ready (stage_ready),
      .out_req   (stage_req)
   );

   // Held request moves into the result register when that is free
   assign stage_ready = !rsp_valid_ff || rsp_tready;
   assign advance     = stage_valid && stage_ready;

   btms_step u_step (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .period  (period_ff),
      .req     (stage_req),
      .rsp     (step_rsp)
   );

   // Result register
   assign rsp_valid_in = advance ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (advance) begin
         rsp_ff <= step_rsp;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_ff};

   // Period register
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff <= btms_pkg::PERIOD_RESET;
      end else if (csr_valid && csr_ready) begin
         period_ff <= csr_data;
      end
   end

   // A tick that moves on always shows up as a result next cycle
   a_advance_shows: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid_ff)
      else $error("tick update lost its result");

   // A held request is never dropped while the result side stalls
   a_stage_holds: assert property (@(posedge clock) disable iff (reset)
      stage_valid && !stage_ready |=> stage_valid && $stable(stage_req))
      else $error("held request dropped under stall");

   // Drivers are off outside the test modes
   a_standby_off: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_ff.mode == btms_pkg::MODE_SCAN ||
                       rsp_ff.mode == btms_pkg::MODE_BATLOW)
      |-> !rsp_ff.standby1 && !rsp_ff.standby2)
      else $error("standby on outside test modes");

   // Sensor select stays in 1..4
   a_sensor_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_ff.sensor_select != 3'd0 && rsp_ff.sensor_select <= 3'd4)
      else $error("sensor select out of range");

endmodule
